@@ rtl/core/ptw_pkg.sv @@
package ptw_pkg;

    localparam int DEF_STORE_ENTRIES = 4096;

    localparam int VA_W      = 48;
    localparam int PA_W      = 32;
    localparam int FRAME_W   = 20;
    localparam int IDX_W     = 9;
    localparam int OFF_W     = 12;
    localparam int ENTRY_W   = 32;
    localparam int IN_IDX_W  = 12;
    // Entry slot before wrapping to the store depth: byte address over eight.
    localparam int SLOT_W    = PA_W - 3;
    localparam int LARGE_BIT = 7;

    localparam int L4_LSB = 39;
    localparam int L3_LSB = 30;
    localparam int L2_LSB = 21;
    localparam int L1_LSB = 12;

    typedef enum logic [0:0] {
        OP_LOAD      = 1'b0,
        OP_TRANSLATE = 1'b1
    } t_opcode;

    typedef struct packed {
        logic               wr_en;
        logic [SLOT_W-1:0]  wr_slot;
        logic [ENTRY_W-1:0] wr_data;
        logic               rd_en;
        logic [SLOT_W-1:0]  rd_slot;
    } t_store_req;

endpackage

@@ rtl/core/ptw_store.sv @@
module ptw_store #(
    parameter int STORE_ENTRIES = ptw_pkg::DEF_STORE_ENTRIES
) (
    input  logic                         i_clk,
    input  ptw_pkg::t_store_req          i_req,
    output logic [ptw_pkg::ENTRY_W-1:0]  o_rd_data
);
    import ptw_pkg::*;

    localparam int AW = $clog2(STORE_ENTRIES);

    logic [ENTRY_W-1:0] r_mem [STORE_ENTRIES];
    logic [ENTRY_W-1:0] r_rd_data;

    // Slots wrap at the store depth: keep the low address bits only.
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_slot[AW-1:0]] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_slot[AW-1:0]];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/core/ptw_ctrl.sv @@
module ptw_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [ptw_pkg::FRAME_W-1:0]   i_cfg_wr_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_opcode,
    input  logic [ptw_pkg::IN_IDX_W-1:0]  i_entry_index,
    input  logic [ptw_pkg::ENTRY_W-1:0]   i_entry_value,
    input  logic [ptw_pkg::VA_W-1:0]      i_virtual_address,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [ptw_pkg::PA_W-1:0]      o_physical_address,
    output logic                          o_large_page,
    output ptw_pkg::t_store_req           o_req,
    input  logic [ptw_pkg::ENTRY_W-1:0]   i_rd_data
);
    import ptw_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_L4   = 5'b00010,
        S_L3   = 5'b00100,
        S_L2   = 5'b01000,
        S_L1   = 5'b10000
    } t_walk_state;

    t_walk_state          r_state, n_state;
    logic [FRAME_W-1:0]   r_base_frame;
    logic [L4_LSB-1:0]    r_va, n_va;
    logic                 r_out_valid, n_out_valid;
    logic [PA_W-1:0]      r_out_pa, n_out_pa;
    logic                 r_out_large, n_out_large;
    logic                 out_load;
    logic                 out_free;
    logic [FRAME_W-1:0]   ent_frame;

    assign ent_frame = i_rd_data[ENTRY_W-1:OFF_W];
    assign out_free  = !r_out_valid || !i_stall;

    always_comb begin
        n_state       = r_state;
        n_va          = r_va;
        n_out_pa      = r_out_pa;
        n_out_large   = r_out_large;
        out_load      = 1'b0;
        o_req.wr_en   = 1'b0;
        o_req.wr_slot = {{(SLOT_W-IN_IDX_W){1'b0}}, i_entry_index};
        o_req.wr_data = i_entry_value;
        o_req.rd_en   = 1'b0;
        o_req.rd_slot = {ent_frame, r_va[L3_LSB +: IDX_W]};
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_opcode == OP_LOAD) begin
                        o_req.wr_en = 1'b1;
                    end else begin
                        o_req.rd_en   = 1'b1;
                        o_req.rd_slot = {r_base_frame, i_virtual_address[L4_LSB +: IDX_W]};
                        n_va          = i_virtual_address[L4_LSB-1:0];
                        n_state       = S_L4;
                    end
                end
            end
            S_L4: begin
                o_req.rd_en   = 1'b1;
                o_req.rd_slot = {ent_frame, r_va[L3_LSB +: IDX_W]};
                n_state       = S_L3;
            end
            S_L3: begin
                o_req.rd_en   = 1'b1;
                o_req.rd_slot = {ent_frame, r_va[L2_LSB +: IDX_W]};
                n_state       = S_L2;
            end
            S_L2: begin
                if (i_rd_data[LARGE_BIT]) begin
                    // 2 MB page: frame plus the 21-bit offset, wrapping at 32 bits
                    if (out_free) begin
                        out_load    = 1'b1;
                        n_out_pa    = {ent_frame + {{(FRAME_W-IDX_W){1'b0}},
                                                    r_va[L1_LSB +: IDX_W]},
                                       r_va[OFF_W-1:0]};
                        n_out_large = 1'b1;
                        n_state     = S_IDLE;
                    end
                end else begin
                    o_req.rd_en   = 1'b1;
                    o_req.rd_slot = {ent_frame, r_va[L1_LSB +: IDX_W]};
                    n_state       = S_L1;
                end
            end
            S_L1: begin
                // hold the read data until the output register frees up
                if (out_free) begin
                    out_load    = 1'b1;
                    n_out_pa    = {ent_frame, r_va[OFF_W-1:0]};
                    n_out_large = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = (r_out_valid && i_stall) || out_load;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_base_frame <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_base_frame <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_va        <= n_va;
        r_out_pa    <= n_out_pa;
        r_out_large <= n_out_large;
    end

    assign o_stall            = (r_state != S_IDLE);
    assign o_valid            = r_out_valid;
    assign o_physical_address = r_out_pa;
    assign o_large_page       = r_out_large;

endmodule

@@ rtl/core/four_level_page_table_walker.sv @@
// Four-level page table walker. Load words write one 32-bit entry into the
// internal entry store at slot entry_index (wrapped to the store depth) and
// give no result. Translate words walk PML4, PDPT and PD from the table base
// frame register and end at a 2 MB page when bit 7 of the PD entry is set,
// or read one PT entry more for a 4 KB page. Every step is a dependent read
// of the registered entry store, so a translation stalls the input through
// states S_L4, S_L3 and S_L2 and, for a 4 KB page, S_L1, and loads the result
// register from S_L2 or S_L1 once a full output register has drained. Loads
// are taken while an earlier result still waits at the output. Present and
// 1 GB page bits are not checked. STORE_ENTRIES must be a power of two;
// entries read before any load wrote them return undefined data.
module four_level_page_table_walker #(
    parameter int STORE_ENTRIES = ptw_pkg::DEF_STORE_ENTRIES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [ptw_pkg::FRAME_W-1:0]   i_cfg_wr_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_opcode,
    input  logic [ptw_pkg::IN_IDX_W-1:0]  i_entry_index,
    input  logic [ptw_pkg::ENTRY_W-1:0]   i_entry_value,
    input  logic [ptw_pkg::VA_W-1:0]      i_virtual_address,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [ptw_pkg::PA_W-1:0]      o_physical_address,
    output logic                          o_large_page
);
    import ptw_pkg::*;

    t_store_req         store_req;
    logic [ENTRY_W-1:0] store_rd_data;

    ptw_ctrl u_ctrl (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_wr_data      (i_cfg_wr_data),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_opcode           (i_opcode),
        .i_entry_index      (i_entry_index),
        .i_entry_value      (i_entry_value),
        .i_virtual_address  (i_virtual_address),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_physical_address (o_physical_address),
        .o_large_page       (o_large_page),
        .o_req              (store_req),
        .i_rd_data          (store_rd_data)
    );

    ptw_store #(
        .STORE_ENTRIES (STORE_ENTRIES)
    ) u_store (
        .i_clk     (i_clk),
        .i_req     (store_req),
        .o_rd_data (store_rd_data)
    );

endmodule

@@ rtl/core/ptw_checker.sv @@
module ptw_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          o_stall,
    input  logic                          i_opcode,
    input  logic                          o_valid,
    input  logic                          i_stall,
    input  logic [ptw_pkg::PA_W-1:0]      o_physical_address,
    input  logic                          o_large_page
);
    import ptw_pkg::*;

    // a translate word keeps the block busy on the next cycle
    a_walk_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_opcode == OP_TRANSLATE) |=> o_stall)
        else $error("translate accepted but input not stalled next cycle");

    // a load word finishes at once and never blocks the next word
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_opcode == OP_LOAD) |=> !o_stall)
        else $error("load accepted but input stalled next cycle");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> ($stable(o_physical_address) && $stable(o_large_page)))
        else $error("stalled result changed");

endmodule

bind four_level_page_table_walker ptw_checker u_ptw_checker (.*);
